// ===== hw/rtl/itwd_pkg.sv =====
// Shared types, constants and helpers for the interval timer.
`default_nettype none
package itwd_pkg;

  localparam int unsigned MAX_FIRES = 255;
  localparam int unsigned US_PER_MS = 1000;

  localparam int unsigned ELAPSED_W = 28;
  localparam int unsigned TIME_W    = 27;
  localparam int unsigned FIRE_W    = 8;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = {ELAPSED_W{1'b1}};
  localparam logic [TIME_W-1:0]    PERIOD_RESET  = TIME_W'(10_000_000);
  localparam logic [FIRE_W-1:0]    FIRES_LIMIT   = FIRE_W'(MAX_FIRES);

  typedef logic [2:0] req_t;
  localparam req_t REQ_TICK  = 3'd0;
  localparam req_t REQ_START = 3'd1;
  localparam req_t REQ_EXCL  = 3'd2;
  localparam req_t REQ_STOP  = 3'd3;
  localparam req_t REQ_LOCK  = 3'd4;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [ELAPSED_W-1:0] a;
    logic [ELAPSED_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0] sum;
    logic                 carry;  // for subtract: 1 means a >= b
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MULP,
    ST_MULD,
    ST_SUM,
    ST_ADD,
    ST_DLIM,
    ST_CHK,
    ST_FIRE,
    ST_LIM,
    ST_OUT
  } state_t;

  // milliseconds to microseconds
  function automatic logic [TIME_W-1:0] ms_to_us(input logic [15:0] ms);
    logic [TIME_W-1:0] prod;
    prod = TIME_W'(ms) * TIME_W'(US_PER_MS);
    return prod;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/itwd_alu.sv =====
// Shared 28-bit add/subtract unit used by the timer sequencer.
`default_nettype none
module itwd_alu import itwd_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ELAPSED_W-1:0] b_op;
  logic [ELAPSED_W:0]   total;

  always_comb begin
    b_op  = (req.op == ALU_SUB) ? ~req.b : req.b;
    total = {1'b0, req.a} + {1'b0, b_op} + (ELAPSED_W+1)'(req.op == ALU_SUB);
    rsp.sum   = total[ELAPSED_W-1:0];
    rsp.carry = total[ELAPSED_W];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/interval_timer_with_delay.sv =====
// Interval timer with post-expiry delay: sequencer around one add/subtract unit.
// Sequence: stop, lock, unknown commands and ticks to an idle timer go from decode
// straight to the result; an accepted start converts period and delay and registers
// their sum as the limit; other ticks add dt, then check the limit in a delay phase
// or else run the expiry loop. Each expiry runs compare and subtract, plus a limit
// check when a delay is set. One transaction at a time: in_ready is high only while
// idle, which is re-entered once the result has been taken.
// Reset (synchronous, rst_n low): elapsed 0, period 10 s, delay 0, inactive,
// periodic, unlocked, no delay phase; no result pending.
`default_nettype none
module interval_timer_with_delay import itwd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [19:0] in_dt_us,
  input  wire logic [15:0] in_period_ms,
  input  wire logic [15:0] in_delay_ms,
  input  wire logic        in_repeat_flag,
  input  wire logic        in_lock_flag,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_fire_count,
  output logic             out_fire_capped,
  output logic             out_timer_active,
  output logic             out_delay_phase,
  output logic             out_start_locked,
  output logic             out_start_taken
);

  state_t state_r, state_nxt;

  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]    period_r, period_nxt;
  logic [TIME_W-1:0]    delay_r, delay_nxt;
  logic [TIME_W-1:0]    limit_r, limit_nxt;
  logic                 active_r, active_nxt;
  logic                 repeat_r, repeat_nxt;
  logic                 lock_r, lock_nxt;
  logic                 delay_bit_r, delay_bit_nxt;
  logic [FIRE_W-1:0]    fires_r, fires_nxt;
  logic                 capped_r, capped_nxt;
  logic                 taken_r, taken_nxt;

  // latched command
  req_t        req_r;
  logic [19:0] dt_r;
  logic [15:0] pms_r;
  logic [15:0] dms_r;
  logic        rep_in_r;
  logic        lock_in_r;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic in_fire;

  itwd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign out_valid        = (state_r == ST_OUT);
  assign out_fire_count   = fires_r;
  assign out_fire_capped  = capped_r;
  assign out_timer_active = active_r;
  assign out_delay_phase  = delay_bit_r;
  assign out_start_locked = lock_r;
  assign out_start_taken  = taken_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      period_r    <= PERIOD_RESET;
      delay_r     <= '0;
      limit_r     <= PERIOD_RESET;
      active_r    <= 1'b0;
      repeat_r    <= 1'b1;
      lock_r      <= 1'b0;
      delay_bit_r <= 1'b0;
      fires_r     <= '0;
      capped_r    <= 1'b0;
      taken_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      elapsed_r   <= elapsed_nxt;
      period_r    <= period_nxt;
      delay_r     <= delay_nxt;
      limit_r     <= limit_nxt;
      active_r    <= active_nxt;
      repeat_r    <= repeat_nxt;
      lock_r      <= lock_nxt;
      delay_bit_r <= delay_bit_nxt;
      fires_r     <= fires_nxt;
      capped_r    <= capped_nxt;
      taken_r     <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r     <= in_req_type;
      dt_r      <= in_dt_us;
      pms_r     <= in_period_ms;
      dms_r     <= in_delay_ms;
      rep_in_r  <= in_repeat_flag;
      lock_in_r <= in_lock_flag;
    end
  end

  // operand steering for the shared unit
  always_comb begin
    alu_req.op = ALU_SUB;
    alu_req.a  = elapsed_r;
    alu_req.b  = ELAPSED_W'(period_r);
    case (state_r)
      ST_SUM: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = ELAPSED_W'(period_r);
        alu_req.b  = ELAPSED_W'(delay_r);
      end
      ST_ADD: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = elapsed_r;
        alu_req.b  = ELAPSED_W'(dt_r);
      end
      ST_DLIM: begin
        alu_req.a = ELAPSED_W'(limit_r);
        alu_req.b = elapsed_r;
      end
      ST_CHK: begin
        alu_req.a = ELAPSED_W'(period_r);
        alu_req.b = elapsed_r;
      end
      ST_LIM: begin
        alu_req.a = elapsed_r;
        alu_req.b = ELAPSED_W'(limit_r);
      end
      default: begin
        alu_req.op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    elapsed_nxt   = elapsed_r;
    period_nxt    = period_r;
    delay_nxt     = delay_r;
    limit_nxt     = limit_r;
    active_nxt    = active_r;
    repeat_nxt    = repeat_r;
    lock_nxt      = lock_r;
    delay_bit_nxt = delay_bit_r;
    fires_nxt     = fires_r;
    capped_nxt    = capped_r;
    taken_nxt     = taken_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        fires_nxt  = '0;
        capped_nxt = 1'b0;
        taken_nxt  = 1'b0;
        state_nxt  = ST_OUT;
        case (req_r)
          REQ_TICK: begin
            if (delay_bit_r || active_r) begin
              state_nxt = ST_ADD;
            end
          end
          REQ_START: begin
            if (!active_r && !lock_r) begin
              taken_nxt = 1'b1;
              state_nxt = ST_MULP;
            end
          end
          REQ_EXCL: begin
            if (!active_r && !lock_r && (elapsed_r == '0)) begin
              taken_nxt = 1'b1;
              state_nxt = ST_MULP;
            end
          end
          REQ_STOP: begin
            if (active_r) begin
              active_nxt  = 1'b0;
              elapsed_nxt = '0;
            end
          end
          REQ_LOCK: begin
            lock_nxt = lock_in_r;
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end
      ST_MULP: begin
        period_nxt = ms_to_us(pms_r);
        repeat_nxt = rep_in_r;
        lock_nxt   = lock_in_r;
        active_nxt = 1'b1;
        state_nxt  = ST_MULD;
      end
      ST_MULD: begin
        delay_nxt = ms_to_us(dms_r);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // both terms stay below 2^26 - period + delay fits 27 bits
        limit_nxt = alu_rsp.sum[TIME_W-1:0];
        state_nxt = ST_OUT;
      end
      ST_ADD: begin
        elapsed_nxt = alu_rsp.carry ? ELAPSED_MAX : alu_rsp.sum;
        state_nxt   = delay_bit_r ? ST_DLIM : ST_CHK;
      end
      ST_DLIM: begin
        // borrow: elapsed beyond period plus delay, delay phase over
        if (!alu_rsp.carry) begin
          elapsed_nxt   = '0;
          delay_bit_nxt = 1'b0;
        end
        state_nxt = ST_OUT;
      end
      ST_CHK: begin
        state_nxt = ST_OUT;
        if (!alu_rsp.carry) begin
          if (fires_r >= FIRES_LIMIT) begin
            capped_nxt = 1'b1;
          end else begin
            state_nxt = ST_FIRE;
          end
        end
      end
      ST_FIRE: begin
        if (repeat_r) begin
          elapsed_nxt = alu_rsp.sum;
        end else if (delay_r == '0) begin
          elapsed_nxt = '0;
        end
        active_nxt = repeat_r;
        fires_nxt  = fires_r + FIRE_W'(1);
        if (delay_r != '0) begin
          state_nxt = ST_LIM;
        end else begin
          state_nxt = repeat_r ? ST_CHK : ST_OUT;
        end
      end
      ST_LIM: begin
        if (!alu_rsp.carry) begin
          delay_bit_nxt = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          state_nxt = repeat_r ? ST_CHK : ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/itwd_chk.sv =====
// Port-level checks for the interval timer, bound to the top level.
`default_nettype none
module itwd_chk import itwd_pkg::*; (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_fire_count,
  input wire logic        out_fire_capped,
  input wire logic        out_timer_active,
  input wire logic        out_delay_phase,
  input wire logic        out_start_locked,
  input wire logic        out_start_taken
);

  // one transaction in flight: never ready while a result is shown
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_fire_count)
                                   && $stable(out_fire_capped)
                                   && $stable(out_timer_active)
                                   && $stable(out_delay_phase)
                                   && $stable(out_start_locked)
                                   && $stable(out_start_taken)))
    else $error("stalled result changed");

  a_cap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fire_capped) |-> (out_fire_count == FIRES_LIMIT))
    else $error("capped flag without full fire count");

  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_start_taken) |-> (out_timer_active && (out_fire_count == '0)))
    else $error("accepted start left timer inactive or reported fires");

endmodule

bind interval_timer_with_delay itwd_chk u_itwd_chk (.*);
`default_nettype wire
